FILE: hdl/kclc_pkg.sv
// Package for the keypad code lock controller.
// Holds the command, key, mode, event and register index codes, the start code
// and the sequencer state type. It has no dependencies.
`default_nettype none

package kclc_pkg;

  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [3:0] KEY_BACK    = 4'd10;
  localparam logic [3:0] KEY_CONFIRM = 4'd11;
  localparam logic [3:0] KEY_OPEN    = 4'd12;
  localparam logic [3:0] KEY_CHANGE  = 4'd13;

  localparam logic [2:0] M_UNLOCK = 3'd0;
  localparam logic [2:0] M_CHOOSE = 3'd1;
  localparam logic [2:0] M_NEW    = 3'd2;
  localparam logic [2:0] M_REPEAT = 3'd3;
  localparam logic [2:0] M_LOCKED = 3'd4;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_DIGIT    = 4'd1;
  localparam logic [3:0] EV_ERASE    = 4'd2;
  localparam logic [3:0] EV_GRANTED  = 4'd3;
  localparam logic [3:0] EV_WRONG    = 4'd4;
  localparam logic [3:0] EV_LOCKOUT  = 4'd5;
  localparam logic [3:0] EV_TIMEOUT  = 4'd6;
  localparam logic [3:0] EV_OPEN     = 4'd7;
  localparam logic [3:0] EV_STORED   = 4'd8;
  localparam logic [3:0] EV_CHANGED  = 4'd9;
  localparam logic [3:0] EV_MISMATCH = 4'd10;
  localparam logic [3:0] EV_RELEASED = 4'd11;

  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_ATTEMPTS = 1'b1;

  localparam logic [7:0] TIMEOUT_RST  = 8'd60;
  localparam logic [2:0] ATTEMPTS_RST = 3'd3;

  localparam int unsigned START_LEN = 6;
  localparam logic [3:0] START_CODE [0:START_LEN-1] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6};

  localparam int unsigned COUNT_W = 4;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CMP    = 6'b000100,
    S_COPY   = 6'b001000,
    S_FINISH = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  function automatic logic [3:0] start_digit(int unsigned i);
    logic [3:0] d;
    d = 4'd0;
    if (i < START_LEN) begin
      d = START_CODE[i[2:0]];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/keypad_code_lock_controller_unit.sv
// Keypad code lock controller, top level.
// Uses kclc_pkg for its codes, start code and sequencer state type.
//
// Input channel: in_tuser carries the command (key press, timer tick, manager
// release) and in_tdata the key code. One result leaves on the output channel
// for every input transfer, in order: the event, the lock mode, the number of
// digits in the entry buffer and the count of wrong unlock entries.
// The configuration port writes the timeout in ticks and the attempt limit;
// it is to be written only while idle; the block itself does not enforce it.
// An item passes through accept, decode and result load. A confirm that
// compares a code walks the digits one at a time through the single digit
// comparator, stopping at the first mismatch; one that stores a code copies
// them; both then apply the outcome. in_tready is high only between items.
// The result sits in an output register; a stalled receiver lets the next item
// be accepted and decoded, and that item then waits for the register to free.
// Reset restores the start code 123456, the unlock entry mode, an empty buffer
// and the register defaults (60 ticks, 3 attempts).
`default_nettype none

module keypad_code_lock_controller_unit
  import kclc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] key_code, [7:4] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [3:0] event_res, [6:4] mode,
                                       // [10:7] entered_count, [13:11] failures
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int unsigned LW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DIGITS);
  localparam logic [LW-1:0] RST_CODE_LEN =
    LW'((MAX_DIGITS < START_LEN) ? MAX_DIGITS : START_LEN);

  seq_state_t    state_r, state_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [3:0]    key_r, key_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] code_len_r, code_len_nxt;
  logic [2:0]    wrong_r, wrong_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic          timer_on_r, timer_on_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          match_r, match_nxt;
  logic [3:0]    ev_r, ev_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;
  logic [7:0]    timeout_r;
  logic [2:0]    attempts_r;

  logic [3:0]    entry_r [MAX_DIGITS];
  logic [3:0]    code_r  [MAX_DIGITS];

  logic          entry_we;
  logic          code_we;
  logic          fin;
  logic          in_entry;
  logic          digit_eq;
  logic          idx_last;
  logic [7:0]    idle_inc;
  logic [2:0]    wrong_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign digit_eq = (entry_r[idx_r] == code_r[idx_r]);
  assign idx_last = ((LW'(idx_r) + LW'(1)) == len_r);
  assign idle_inc = idle_r + 8'd1;
  assign wrong_inc = wrong_r + 3'd1;

  always_comb begin
    in_entry = 1'b0;
    case (mode_r) inside
      M_UNLOCK, M_NEW, M_REPEAT: in_entry = 1'b1;
      default: in_entry = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    code_len_nxt  = code_len_r;
    wrong_nxt     = wrong_r;
    idle_nxt      = idle_r;
    timer_on_nxt  = timer_on_r;
    idx_nxt       = idx_r;
    match_nxt     = match_r;
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    entry_we      = 1'b0;
    code_we       = 1'b0;
    fin           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          key_nxt   = in_tdata[3:0];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ev_nxt    = EV_NONE;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_KEY: begin
            if (in_entry) begin
              if (key_r == KEY_BACK) begin
                if (len_r != '0) begin
                  len_nxt  = len_r - LW'(1);
                  idle_nxt = 8'd0;
                  ev_nxt   = EV_ERASE;
                end
              end else if (key_r == KEY_CONFIRM || (key_r < KEY_BACK && len_r >= MAX_LEN)) begin
                fin = 1'b1;
              end else if (key_r < KEY_BACK) begin
                entry_we     = 1'b1;
                len_nxt      = len_r + LW'(1);
                timer_on_nxt = 1'b1;
                idle_nxt     = 8'd0;
                ev_nxt       = EV_DIGIT;
              end
            end else if (mode_r == M_CHOOSE) begin
              if (key_r == KEY_OPEN) begin
                mode_nxt  = M_UNLOCK;
                wrong_nxt = 3'd0;
                ev_nxt    = EV_OPEN;
              end else if (key_r == KEY_CHANGE) begin
                mode_nxt = M_NEW;
              end
              len_nxt      = '0;
              timer_on_nxt = 1'b0;
              idle_nxt     = 8'd0;
            end
          end
          CMD_TICK: begin
            if (in_entry && timer_on_r) begin
              idle_nxt = idle_inc;
              if (idle_inc == timeout_r) begin
                if (mode_r == M_UNLOCK) begin
                  wrong_nxt    = 3'd0;
                  len_nxt      = '0;
                  timer_on_nxt = 1'b0;
                  idle_nxt     = 8'd0;
                  ev_nxt       = EV_TIMEOUT;
                end else begin
                  fin = 1'b1;
                end
              end
            end
          end
          CMD_RELEASE: begin
            if (mode_r == M_LOCKED) begin
              mode_nxt     = M_UNLOCK;
              wrong_nxt    = 3'd0;
              len_nxt      = '0;
              timer_on_nxt = 1'b0;
              idle_nxt     = 8'd0;
              ev_nxt       = EV_RELEASED;
            end
          end
          default: ;
        endcase
        if (fin) begin
          idx_nxt   = '0;
          match_nxt = 1'b0;
          if (mode_r == M_NEW) begin
            state_nxt = (len_r == '0) ? S_FINISH : S_COPY;
          end else begin
            state_nxt = (len_r == '0 || len_r != code_len_r) ? S_FINISH : S_CMP;
          end
        end
      end
      S_CMP: begin
        if (!digit_eq) begin
          match_nxt = 1'b0;
          state_nxt = S_FINISH;
        end else if (idx_last) begin
          match_nxt = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_COPY: begin
        code_we = 1'b1;
        if (idx_last) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_FINISH: begin
        ev_nxt = EV_NONE;
        case (mode_r)
          M_UNLOCK: begin
            if (match_r) begin
              wrong_nxt = 3'd0;
              mode_nxt  = M_CHOOSE;
              ev_nxt    = EV_GRANTED;
            end else begin
              wrong_nxt = wrong_inc;
              if (wrong_inc >= attempts_r) begin
                mode_nxt = M_LOCKED;
                ev_nxt   = EV_LOCKOUT;
              end else begin
                ev_nxt = EV_WRONG;
              end
            end
          end
          M_NEW: begin
            code_len_nxt = len_r;
            mode_nxt     = M_REPEAT;
            ev_nxt       = EV_STORED;
          end
          M_REPEAT: begin
            if (match_r) begin
              wrong_nxt = 3'd0;
              mode_nxt  = M_UNLOCK;
              ev_nxt    = EV_CHANGED;
            end else begin
              mode_nxt = M_NEW;
              ev_nxt   = EV_MISMATCH;
            end
          end
          default: ;
        endcase
        len_nxt      = '0;
        timer_on_nxt = 1'b0;
        idle_nxt     = 8'd0;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, wrong_r, COUNT_W'(len_r), mode_r, ev_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_UNLOCK;
      len_r       <= '0;
      code_len_r  <= RST_CODE_LEN;
      wrong_r     <= 3'd0;
      idle_r      <= 8'd0;
      timer_on_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      attempts_r  <= ATTEMPTS_RST;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      code_len_r  <= code_len_nxt;
      wrong_r     <= wrong_nxt;
      idle_r      <= idle_nxt;
      timer_on_r  <= timer_on_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
          CFG_ATTEMPTS: attempts_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    match_r    <= match_nxt;
    ev_r       <= ev_nxt;
    out_data_r <= out_data_nxt;
    if (entry_we) begin
      entry_r[len_r[IW-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
        code_r[i] <= start_digit(i);
      end
    end else if (code_we) begin
      code_r[idx_r] <= entry_r[idx_r];
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MAX_LEN)
    else $error("Entry length exceeds the buffer depth.");

  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !timer_on_r |-> idle_r == 8'd0)
    else $error("Idle counter runs while the timer is off.");

  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_CHOOSE || mode_r == M_LOCKED) |-> len_r == '0)
    else $error("Entry buffer is not empty outside an entry mode.");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_COPY) |-> LW'(idx_r) < len_r)
    else $error("Digit walk runs past the entry length.");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_DECODE)
    else $error("An accepted transfer was not decoded.");

endmodule

`default_nettype wire
